// ===== rtl/core/emboss_filter_3x3_rgb_top_macros.svh =====
// Assertion macros used by the port-level emboss filter checker.
`ifndef EMBOSS_FILTER_3X3_RGB_TOP_MACROS_SVH
`define EMBOSS_FILTER_3X3_RGB_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define EFRGB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("emboss filter check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define EFRGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("emboss filter check failed");

`endif

// ===== rtl/core/efrgb_pkg.sv =====
// Constants, register codes and the emboss kernel for the 3x3 emboss filter.
`default_nettype none

package efrgb_pkg;

  localparam int PIX_W      = 8;     // bits per colour channel
  localparam int PORT_CH    = 3;     // channel ports on the interface
  localparam int PIX_MAX    = 255;
  localparam int ROW_W      = 12;    // row counter and out_row
  localparam int HGT_W      = 13;    // image_height register
  localparam int WID_W      = 12;    // image_width register
  localparam int OCOL_W     = 11;    // out_col
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;
  localparam int W_RESET    = 640;
  localparam int H_RESET    = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // 2*up_left - centre - down_right, clamped to 0..255
  function automatic logic [PIX_W-1:0] emboss_px(input logic [PIX_W-1:0] ul,
                                                 input logic [PIX_W-1:0] ctr,
                                                 input logic [PIX_W-1:0] cur);
    logic signed [PIX_W+2:0] sum;
    sum = $signed({2'b00, ul, 1'b0}) - $signed({3'b000, ctr})
        - $signed({3'b000, cur});
    if (sum < 0) begin
      return '0;
    end else if (sum > PIX_MAX) begin
      return PIX_W'(PIX_MAX);
    end else begin
      return sum[PIX_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/efrgb_line_buf.sv =====
// Two ping-pong row stores with registered, read-first read ports.
`default_nettype none

module efrgb_line_buf #(
  parameter int MAX_WIDTH = 2048,
  parameter int DW        = 24,
  parameter int AW        = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,     // pixel transfer this cycle
  input  wire logic          odd_i,    // row parity of that pixel
  input  wire logic [AW-1:0] col_i,
  input  wire logic [DW-1:0] pix_i,
  output      logic [DW-1:0] fresh_o,  // row r-2 at column c
  output      logic [DW-1:0] ctr_o     // row r-1 at column c-1
);

  logic [DW-1:0] older_mem [MAX_WIDTH];
  logic [DW-1:0] newer_mem [MAX_WIDTH];
  logic [DW-1:0] older_rd_q, newer_rd_q;
  logic          odd_q;
  logic [AW-1:0] col_m1, older_ra, newer_ra;

  assign col_m1   = col_i - AW'(1);
  // store being written reads at c (old value), the other one at c-1
  assign older_ra = odd_i ? col_m1 : col_i;
  assign newer_ra = odd_i ? col_i  : col_m1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      older_rd_q <= older_mem[older_ra];
      if (!odd_i) begin
        older_mem[col_i] <= pix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      newer_rd_q <= newer_mem[newer_ra];
      if (odd_i) begin
        newer_mem[col_i] <= pix_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q <= 1'b0;
    end else if (en_i) begin
      odd_q <= odd_i;
    end
  end

  assign fresh_o = odd_q ? newer_rd_q : older_rd_q;
  assign ctr_o   = odd_q ? older_rd_q : newer_rd_q;

endmodule

`default_nettype wire

// ===== rtl/core/emboss_filter_3x3_rgb_top.sv =====
// Top level of the streaming 3x3 emboss filter for three-channel pixels.
`default_nettype none

// Streaming 3x3 emboss filter. Pixels arrive in raster order, one per input
// transfer, and each channel is filtered as 2*up-left - centre - down-right,
// clamped to 0..255. The result for position (r-1,c-1) leaves when the pixel
// at (r,c) arrives, so nothing comes out for the first row or first column
// of input, and the last row and last column of results are never sent: the
// consumer fills those in with zero. Results on the top row or left column
// are sent as zero. Throughput is one pixel per clock with both sides ready.
// On its pixel transfer the pixel is registered into stage 1 together with
// the synchronous row-store read; when stage 1 advances, the kernel and
// clamp are registered into the result register, which drives the output.
// Back-pressure on the output stalls the input only when a result is still
// waiting there and the stage behind it holds another one. The row stores
// are two single-port-read arrays of MAX_WIDTH x 24 bits; their contents are
// not cleared, nor need they be, since no entry is used before it is written
// in the current frame. Writing either configuration register restarts the
// frame at (0,0); write it only while the block is idle. Width is clamped to
// 3..MAX_WIDTH and height to 3..4096.
module emboss_filter_3x3_rgb_top
  import efrgb_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int CHANNELS  = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [PIX_W-1:0]      in_chan0_i,
  input  wire logic [PIX_W-1:0]      in_chan1_i,
  input  wire logic [PIX_W-1:0]      in_chan2_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [PIX_W-1:0]      out_chan0_o,
  output      logic [PIX_W-1:0]      out_chan1_o,
  output      logic [PIX_W-1:0]      out_chan2_o,
  output      logic [ROW_W-1:0]      out_row_o,
  output      logic [OCOL_W-1:0]     out_col_o
);

  localparam int AW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;  // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);                     // width limit
  localparam int NCH = (CHANNELS < PORT_CH) ? CHANNELS : PORT_CH; // stored chans
  localparam int DW  = NCH * PIX_W;
  localparam int W_RESET_LIM = (W_RESET > MAX_WIDTH) ? MAX_WIDTH : W_RESET;

  typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

  // Frame geometry, held already clamped
  logic [WW-1:0]    w_lim_q;
  logic [HGT_W-1:0] h_lim_q;

  // Raster position of the next input pixel
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [WW-1:0]    col_inc;
  logic [HGT_W-1:0] row_inc;

  // Stage 1: pixel waiting for its row-store read data
  logic             s1_valid_q, s1_valid_d;
  pix_t             s1_pix_q;
  logic [AW-1:0]    s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic             s1_emit, s1_inner, s1_adv;

  // Up-left taps: row r-2 pixels, tap1 is two columns back
  pix_t tap0_q, tap1_q;

  // Result register
  logic                        out_valid_q, out_valid_d;
  logic [PORT_CH-1:0][PIX_W-1:0] out_chan_q, res_chan;
  logic [ROW_W-1:0]            out_row_q;
  logic [OCOL_W-1:0]           out_col_q;

  logic [PIX_W-1:0] in_ch [PORT_CH];
  pix_t             cur_pix, fresh_pix, ctr_pix;
  logic             accept, out_free;
  logic [WID_W-1:0] cfg_w;
  logic [HGT_W-1:0] cfg_h;

  assign in_ch[0] = in_chan0_i;
  assign in_ch[1] = in_chan1_i;
  assign in_ch[2] = in_chan2_i;

  for (genvar k = 0; k < NCH; k++) begin : g_pack
    assign cur_pix[k] = in_ch[k];
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 moves on when its result has somewhere to go, or
  // when the position gives no result at all.
  // ---------------------------------------------------------------------------
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_emit    = (s1_row_q != '0) && (s1_col_q != '0);
  assign s1_inner   = (s1_row_q > ROW_W'(1)) && (s1_col_q > AW'(1));
  assign s1_adv     = s1_valid_q && (!s1_emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign s1_valid_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = (s1_adv && s1_emit) ? 1'b1
                     : (out_ready_i ? 1'b0 : out_valid_q);

  // ---------------------------------------------------------------------------
  // Raster counters
  // ---------------------------------------------------------------------------
  always_comb begin
    col_inc = WW'(col_q) + WW'(1);
    row_inc = {1'b0, row_q} + HGT_W'(1);
    col_d   = AW'(col_inc);
    row_d   = row_q;
    if (col_inc == w_lim_q) begin
      col_d = '0;
      row_d = (row_inc == h_lim_q) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  // Register writes, clamped on the way in
  assign cfg_w = cfg_data_i[WID_W-1:0];
  assign cfg_h = cfg_data_i[HGT_W-1:0];

  // ---------------------------------------------------------------------------
  // Row stores
  // ---------------------------------------------------------------------------
  efrgb_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .DW        (DW),
    .AW        (AW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .odd_i   (row_q[0]),
    .col_i   (col_q),
    .pix_i   (cur_pix),
    .fresh_o (fresh_pix),
    .ctr_o   (ctr_pix)
  );

  // ---------------------------------------------------------------------------
  // Kernel: unused channels read zero, border positions give zero
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < PORT_CH; k++) begin : g_kern
    if (k < NCH) begin : g_on
      assign res_chan[k] = s1_inner ? emboss_px(tap1_q[k], ctr_pix[k], s1_pix_q[k])
                                    : '0;
    end else begin : g_off
      assign res_chan[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_lim_q     <= WW'(W_RESET_LIM);
      h_lim_q     <= HGT_W'(H_RESET);
      col_q       <= '0;
      row_q       <= '0;
      tap0_q      <= '0;
      tap1_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && ((cfg_idx_i == REG_IMAGE_WIDTH) ||
                       (cfg_idx_i == REG_IMAGE_HEIGHT))) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH: begin
            if (cfg_w < WID_W'(MIN_DIM)) begin
              w_lim_q <= WW'(MIN_DIM);
            end else if (32'(cfg_w) > MAX_WIDTH) begin
              w_lim_q <= WW'(MAX_WIDTH);
            end else begin
              w_lim_q <= WW'(cfg_w);
            end
          end
          REG_IMAGE_HEIGHT: begin
            if (cfg_h < HGT_W'(MIN_DIM)) begin
              h_lim_q <= HGT_W'(MIN_DIM);
            end else if (cfg_h > HGT_W'(MAX_HEIGHT)) begin
              h_lim_q <= HGT_W'(MAX_HEIGHT);
            end else begin
              h_lim_q <= cfg_h;
            end
          end
          default: ;
        endcase
        // new frame starts with the next pixel
        col_q  <= '0;
        row_q  <= '0;
        tap0_q <= '0;
        tap1_q <= '0;
      end else begin
        if (accept) begin
          col_q <= col_d;
          row_q <= row_d;
        end
        if (s1_adv) begin
          tap1_q <= tap0_q;
          tap0_q <= fresh_pix;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= cur_pix;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
    if (s1_adv && s1_emit) begin
      out_chan_q <= res_chan;
      out_row_q  <= s1_row_q - ROW_W'(1);
      out_col_q  <= OCOL_W'(s1_col_q - AW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chan0_o = out_chan_q[0];
  assign out_chan1_o = out_chan_q[1];
  assign out_chan2_o = out_chan_q[2];
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

endmodule

`default_nettype wire

// ===== rtl/core/efrgb_checker.sv =====
// Port-level checker for the emboss filter, bound to the top level.
`default_nettype none
`include "emboss_filter_3x3_rgb_top_macros.svh"

module efrgb_checker
  import efrgb_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [PIX_W-1:0]   out_chan0_o,
  input wire logic [PIX_W-1:0]   out_chan1_o,
  input wire logic [PIX_W-1:0]   out_chan2_o,
  input wire logic [ROW_W-1:0]   out_row_o,
  input wire logic [OCOL_W-1:0]  out_col_o
);

  // a result not taken stays put (valid, row, column and channel 0 are checked)
  `EFRGB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_row_o) && $stable(out_col_o) && $stable(out_chan0_o))

  // top row and left column results are zero
  `EFRGB_ASSERT_NOW(a_border_zero, clk_i, rst_ni, out_valid_o && ((out_row_o == '0) || (out_col_o == '0)), (out_chan0_o == '0) && (out_chan1_o == '0) && (out_chan2_o == '0))

  // input only stalls behind a result that the consumer is holding off
  `EFRGB_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind emboss_filter_3x3_rgb_top efrgb_checker u_efrgb_checker (.*);

`default_nettype wire

// ===== tb/emboss_filter_3x3_rgb_checker.sv =====
// Checker for the 3x3 emboss filter: watches both streams, predicts and compares results.
`default_nettype none

module emboss_filter_3x3_rgb_checker
  import efrgb_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [PIX_W-1:0]      in_chan0_i,
  input  wire logic [PIX_W-1:0]      in_chan1_i,
  input  wire logic [PIX_W-1:0]      in_chan2_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [PIX_W-1:0]      out_chan0_i,
  input  wire logic [PIX_W-1:0]      out_chan1_i,
  input  wire logic [PIX_W-1:0]      out_chan2_i,
  input  wire logic [ROW_W-1:0]      out_row_i,
  input  wire logic [OCOL_W-1:0]     out_col_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PORT_CH-1:0][PIX_W-1:0] chan;
    logic [ROW_W-1:0]              row;
    logic [OCOL_W-1:0]             col;
  } emboss_res_t;

  logic [PORT_CH*PIX_W-1:0] even_row_mem [MAX_WIDTH];
  logic [PORT_CH*PIX_W-1:0] odd_row_mem  [MAX_WIDTH];
  logic [PORT_CH*PIX_W-1:0] tap_q        [2];
  logic [OCOL_W-1:0]        col_cnt;
  logic [ROW_W-1:0]         row_cnt;
  logic [WID_W-1:0]         width_reg;
  logic [HGT_W-1:0]         height_reg;
  emboss_res_t              expected_px_q [$];
  int unsigned              mismatch_cnt;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic restart_frame();
    col_cnt  = '0;
    row_cnt  = '0;
    tap_q[0] = '0;
    tap_q[1] = '0;
  endtask

  function automatic logic [PIX_W-1:0] emboss_value(input logic [PIX_W-1:0] ul,
                                                    input logic [PIX_W-1:0] ctr,
                                                    input logic [PIX_W-1:0] cur);
    int acc;
    acc = 2 * int'(ul) - int'(ctr) - int'(cur);
    if (acc < 0) acc = 0;
    if (acc > PIX_MAX) acc = PIX_MAX;
    return PIX_W'(acc);
  endfunction

  // one accepted pixel: expected result (if any), then store and counter update
  task automatic predict_pixel(input logic [PORT_CH*PIX_W-1:0] px);
    int unsigned w, h, r, c;
    int k;
    logic [PORT_CH*PIX_W-1:0] up_left, centre, stored;
    emboss_res_t res;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    r = row_cnt;
    c = col_cnt;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    up_left = tap_q[1];
    if (r % 2 == 1) begin
      centre = (c >= 1) ? even_row_mem[(c - 1) % MAX_WIDTH] : '0;
      stored = odd_row_mem[c % MAX_WIDTH];
    end else begin
      centre = (c >= 1) ? odd_row_mem[(c - 1) % MAX_WIDTH] : '0;
      stored = even_row_mem[c % MAX_WIDTH];
    end
    if (r >= 1 && c >= 1) begin
      for (k = 0; k < PORT_CH; k++) begin
        res.chan[k] = (r >= 2 && c >= 2) ?
            emboss_value(up_left[k*PIX_W +: PIX_W], centre[k*PIX_W +: PIX_W],
                         px[k*PIX_W +: PIX_W]) : '0;
      end
      res.row = ROW_W'(r - 1);
      res.col = OCOL_W'(c - 1);
      expected_px_q.push_back(res);
    end
    tap_q[1] = tap_q[0];
    tap_q[0] = stored;
    if (r % 2 == 1) odd_row_mem[c % MAX_WIDTH] = px;
    else            even_row_mem[c % MAX_WIDTH] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = OCOL_W'(c);
    row_cnt = ROW_W'(r);
  endtask

  task automatic check_result();
    emboss_res_t got, want;
    int k;
    got.chan[0] = out_chan0_i;
    got.chan[1] = out_chan1_i;
    got.chan[2] = out_chan2_i;
    got.row     = out_row_i;
    got.col     = out_col_i;
    if (expected_px_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result at row %0d col %0d", got.row, got.col));
    end else begin
      want = expected_px_q.pop_front();
      for (k = 0; k < PORT_CH; k++) begin
        if (got.chan[k] !== want.chan[k])
          report_mismatch($sformatf("chan%0d at (%0d,%0d): got %0d want %0d",
                                    k, want.row, want.col, got.chan[k], want.chan[k]));
      end
      if (got.row !== want.row)
        report_mismatch($sformatf("row: got %0d want %0d", got.row, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("col: got %0d want %0d", got.col, want.col));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = WID_W'(W_RESET);
      height_reg = HGT_W'(H_RESET);
      restart_frame();
      expected_px_q.delete();
      mismatch_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) begin
          width_reg = cfg_data_i[WID_W-1:0];
          restart_frame();
        end else if (cfg_idx_i == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data_i[HGT_W-1:0];
          restart_frame();
        end
      end
      if (in_valid_i && in_ready_i) predict_pixel({in_chan2_i, in_chan1_i, in_chan0_i});
      if (out_valid_i && out_ready_i) check_result();
      fail_count_o <= mismatch_cnt;
      pending_o    <= expected_px_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the 3x3 emboss filter: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top
  import efrgb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 1250;   // target pixel count for the small random frames
  localparam int IDLE_GAP    = 8;      // cycles past the last result before a reg write
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int DRAIN_LIMIT = 20000;  // bound on the final drain
  localparam int IDLE_PCT    = 9;      // idle chance per cycle, in percent

  // register indexes past the end of the map; writes to these must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic [PIX_W-1:0]      in_chan0   = '0;
  logic [PIX_W-1:0]      in_chan1   = '0;
  logic [PIX_W-1:0]      in_chan2   = '0;
  logic                  out_ready  = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_chan0;
  logic [PIX_W-1:0]      out_chan1;
  logic [PIX_W-1:0]      out_chan2;
  logic [ROW_W-1:0]      out_row;
  logic [OCOL_W-1:0]     out_col;
  int unsigned           fail_count;
  int unsigned           pending;

  // shared between the stimulus and the receiver process
  bit                    no_idle       = 1'b0;  // quiet stretch: neither side idles
  int unsigned           stall_len_req = 0;     // receiver hold-off request, in cycles

  always #5 clk_i = ~clk_i;

  emboss_filter_3x3_rgb_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_chan0_i  (in_chan0),
    .in_chan1_i  (in_chan1),
    .in_chan2_i  (in_chan2),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_chan0_o (out_chan0),
    .out_chan1_o (out_chan1),
    .out_chan2_o (out_chan2),
    .out_row_o   (out_row),
    .out_col_o   (out_col)
  );

  emboss_filter_3x3_rgb_checker u_emboss_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_chan0_i   (in_chan0),
    .in_chan1_i   (in_chan1),
    .in_chan2_i   (in_chan2),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_chan0_i  (out_chan0),
    .out_chan1_i  (out_chan1),
    .out_chan2_i  (out_chan2),
    .out_row_i    (out_row),
    .out_col_i    (out_col),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Channel values lean on the extremes so the clamp is hit both ways.
  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PIX_W'(PIX_MAX);
      default: return PIX_W'($urandom_range(PIX_MAX));
    endcase
  endfunction

  function automatic logic [3*PIX_W-1:0] rand_pixel();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // Register write: one enable cycle, lowered at the following falling edge,
  // so back-to-back calls never touch cfg_we twice in one step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // One pixel transfer. Random idle cycles go before valid is raised; once
  // raised, valid and payload hold until the transfer at a rising edge.
  task automatic send_pixel(input logic [3*PIX_W-1:0] px);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_chan0 <= px[0*PIX_W +: PIX_W];
    in_chan1 <= px[1*PIX_W +: PIX_W];
    in_chan2 <= px[2*PIX_W +: PIX_W];
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Sender goes quiet until every expected result has left, then allows for
  // pixels still in the pipe that give no result.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // 3x3 frame with the kernel taps placed by hand: top-left, centre, bottom-right.
  task automatic send_frame3(input logic [3*PIX_W-1:0] ul, input logic [3*PIX_W-1:0] ctr,
                             input logic [3*PIX_W-1:0] cur);
    int i;
    for (i = 0; i < 9; i++)
      send_pixel(i == 0 ? ul : i == 4 ? ctr : i == 8 ? cur : rand_pixel());
  endtask

  // One setting of the frame size followed by a run of random pixels.
  // hold_at >= 0 starts the long receiver hold-off at that pixel; a random
  // mid-frame pause drains the block and may slip in an ignored reg write.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_data, input bit set_w,
                           input logic [CFG_DATA_W-1:0] h_data, input bit set_h,
                           input int n_pix, input int hold_at, input bit quiet);
    int i, pause_at;
    wait_idle();
    if (set_w) cfg_write(REG_IMAGE_WIDTH, w_data);
    if (set_h) cfg_write(REG_IMAGE_HEIGHT, h_data);
    no_idle  = quiet;
    pause_at = ($urandom_range(3) == 0) ? int'($urandom_range(n_pix - 1)) : -1;
    for (i = 0; i < n_pix; i++) begin
      if (i == hold_at) stall_len_req = HOLD_CYCLES;
      if (i == pause_at) begin
        wait_idle();
        if ($urandom_range(1))
          cfg_write($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                    CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1)));
      end
      send_pixel(rand_pixel());
    end
    no_idle = 1'b0;
  endtask

  // Receiver: ready drops at random, except in a quiet stretch; a hold-off
  // request keeps it low for the whole count so the block backs up into
  // its input while the sender keeps offering.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_len_req != 0) begin
        out_ready <= 1'b0;
        repeat (stall_len_req - 1) @(negedge clk_i);
        stall_len_req = 0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Overall limit, far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned w, h, ew, eh, n, rand_items, phase_idx, drain;
    int          hold_at;
    bit          set_w, set_h;
    rand_items = 0;
    phase_idx  = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: sizes below the minimum clamp to 3x3, so each frame gives one
    // kernel result. First frame: clamp high, clamp low and a mid value.
    cfg_write(REG_IMAGE_WIDTH, 13'd2);
    cfg_write(REG_IMAGE_HEIGHT, 13'd0);
    send_frame3({8'd100, 8'd0, 8'd255}, {8'd50, 8'd255, 8'd0}, {8'd30, 8'd255, 8'd0});
    // second frame: sums of exactly 255 and exactly zero, then all-zero taps
    send_frame3({8'd0, 8'd128, 8'd255}, {8'd0, 8'd128, 8'd255}, {8'd0, 8'd128, 8'd0});
    // frame wrap, then out-of-map writes mid-frame must leave the counters alone
    repeat (4) send_pixel(rand_pixel());
    wait_idle();
    cfg_write(REG_SPARE_2, '1);
    cfg_write(REG_SPARE_3, '0);
    repeat (5) send_pixel(rand_pixel());

    // Random part: mostly tiny frames, every so often an out-of-range size,
    // a long hold-off or a stretch with no idling at all.
    while (rand_items < RAND_ITEMS) begin
      w  = ($urandom_range(9) == 0) ? $urandom_range(MIN_DIM - 1) : $urandom_range(MIN_DIM, 12);
      h  = ($urandom_range(9) == 0) ? $urandom_range(MIN_DIM - 1) : $urandom_range(MIN_DIM, 10);
      ew = (w < MIN_DIM) ? MIN_DIM : w;
      eh = (h < MIN_DIM) ? MIN_DIM : h;
      n  = ew * eh * $urandom_range(1, 2) + $urandom_range(ew);
      case ($urandom_range(5))
        0:       begin set_w = 1'b1; set_h = 1'b0; end
        1:       begin set_w = 1'b0; set_h = 1'b1; end
        default: begin set_w = 1'b1; set_h = 1'b1; end
      endcase
      if (phase_idx == 0) begin
        set_w = 1'b1;
        set_h = 1'b1;
      end
      hold_at = (phase_idx % 7 == 2) ? int'(n / 2) : -1;
      // bit 12 of the data is outside the width register and must not matter
      run_phase({1'($urandom_range(1)), 12'(w)}, set_w, 13'(h), set_h, n, hold_at,
                phase_idx % 9 == 4);
      rand_items += n;
      phase_idx++;
    end

    // The widest and tallest settings, each for a short run that must not wrap early.
    run_phase(13'h0FFF, 1'b1, 13'd3, 1'b1, 150, 100, 1'b0);
    run_phase(13'd3, 1'b1, 13'h1FFF, 1'b1, 150, -1, 1'b0);

    // Drain and give the verdict.
    @(negedge clk_i);
    in_valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (IDLE_GAP) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
